// ===== sv/mexp_pkg.sv =====
// Shared constants for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

	// width of the base word, fixed by the interface
	localparam int BASE_WIDTH = 63;

endpackage

// ===== sv/modular_exponentiation.sv =====
// Modular exponentiation by right-to-left square-and-multiply with bit-serial arithmetic.
`timescale 1ns / 1ps

// Raises base to exponent modulo modulus, one word at a time. A word is taken when start is
// high and busy is low. The result shows on residue for exactly one cycle with done high, and
// the receiver must take it then. The base is first reduced modulo modulus one bit at a time;
// then each exponent bit, from the lowest up to the highest set one, is handled by two
// modular multiplications (accumulator by square, square by square) that run side by side
// and share one bit-serial multiplier register. A modulus of zero returns 0 in the cycle
// after start.
module modular_exponentiation #(
	parameter int EXP_WIDTH = 63,
	parameter int MOD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [mexp_pkg::BASE_WIDTH-1:0]   base,
	input  logic [EXP_WIDTH-1:0]              exponent,
	input  logic [MOD_WIDTH-1:0]              modulus,
	output logic                              done,
	output logic [MOD_WIDTH-1:0]              residue
);

	localparam int BW    = mexp_pkg::BASE_WIDTH;
	// sized from the base length, so this counter covers both loops only while MOD_WIDTH is at most 64
	localparam int CNT_W = $clog2(BW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MULT
	} state_t;

	state_t                 state_q;
	logic [BW-1:0]          base_q;
	logic [EXP_WIDTH-1:0]   exp_q;
	logic [MOD_WIDTH-1:0]   mod_q;
	logic [MOD_WIDTH-1:0]   sq_q;
	logic [MOD_WIDTH-1:0]   acc_q;
	logic [MOD_WIDTH-1:0]   mb_q;
	logic [MOD_WIDTH-1:0]   pa_q;
	logic [MOD_WIDTH-1:0]   pb_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic [MOD_WIDTH-1:0]   res_q;

	logic [MOD_WIDTH-1:0]   red_next;
	logic [MOD_WIDTH-1:0]   pa_next;
	logic [MOD_WIDTH-1:0]   pb_next;

	// one step of the base reduction: r = (2r + bit) mod m, with r < m on entry
	function automatic logic [MOD_WIDTH-1:0] red_step(
		input logic [MOD_WIDTH-1:0] r,
		input logic                 b,
		input logic [MOD_WIDTH-1:0] m
	);
		logic [MOD_WIDTH:0]   s;
		logic [MOD_WIDTH+1:0] t;
		s = {r, b};
		t = {1'b0, s} - {2'b00, m};
		if (!t[MOD_WIDTH+1]) begin
			red_step = t[MOD_WIDTH-1:0];
		end else begin
			red_step = s[MOD_WIDTH-1:0];
		end
	endfunction

	// one step of interleaved modular multiplication: r = (2r + bit * a) mod m
	function automatic logic [MOD_WIDTH-1:0] mul_step(
		input logic [MOD_WIDTH-1:0] r,
		input logic [MOD_WIDTH-1:0] a,
		input logic                 b,
		input logic [MOD_WIDTH-1:0] m
	);
		logic [MOD_WIDTH+2:0] s;
		logic [MOD_WIDTH+2:0] t1;
		logic [MOD_WIDTH+2:0] t2;
		s  = {2'b00, r, 1'b0} + (b ? {3'b000, a} : '0);
		t1 = s - {3'b000, m};
		t2 = s - {2'b00, m, 1'b0};
		// s is below 3m, so at most two subtractions bring it into range
		if (!t2[MOD_WIDTH+2]) begin
			mul_step = t2[MOD_WIDTH-1:0];
		end else if (!t1[MOD_WIDTH+2]) begin
			mul_step = t1[MOD_WIDTH-1:0];
		end else begin
			mul_step = s[MOD_WIDTH-1:0];
		end
	endfunction

	assign red_next = red_step(sq_q, base_q[BW-1], mod_q);
	assign pa_next  = mul_step(pa_q, acc_q, mb_q[MOD_WIDTH-1], mod_q);
	assign pb_next  = mul_step(pb_q, sq_q, mb_q[MOD_WIDTH-1], mod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						base_q <= base;
						exp_q  <= exponent;
						mod_q  <= modulus;
						sq_q   <= '0;
						cnt_q  <= CNT_W'(BW - 1);
						if (modulus == '0) begin
							// no modulus: answer zero at once
							res_q  <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					sq_q   <= red_next;
					base_q <= {base_q[BW-2:0], 1'b0};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						acc_q   <= (mod_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (exp_q == '0) begin
						res_q   <= acc_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						mb_q    <= sq_q;
						pa_q    <= '0;
						pb_q    <= '0;
						cnt_q   <= CNT_W'(MOD_WIDTH - 1);
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					pa_q  <= pa_next;
					pb_q  <= pb_next;
					mb_q  <= {mb_q[MOD_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						// fold the products back and drop the exponent bit
						if (exp_q[0]) begin
							acc_q <= pa_next;
						end
						sq_q    <= pb_next;
						exp_q   <= exp_q >> 1;
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign residue = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still working");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mod_q != '0) |-> (residue < mod_q))
		else $error("residue not below modulus");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word neither worked on nor answered");

	a_check_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (sq_q < mod_q && acc_q < mod_q))
		else $error("working residues out of range");

	a_mult_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) |-> (cnt_q <= CNT_W'(MOD_WIDTH - 1)))
		else $error("multiplier bit count out of range");

endmodule
